@@ hw/rtl/hbmt_pkg.sv @@
// ----------------------------------------------------------------------------
// hbmt_pkg
// Shared types and constants for the heartbeat membership table.
// ----------------------------------------------------------------------------
`default_nettype none
package hbmt_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] EV_TICK    = 3'd0;
    localparam logic [2:0] EV_REMOVED = 3'd1;
    localparam logic [2:0] EV_ADDED   = 3'd2;
    localparam logic [2:0] EV_UPDATED = 3'd3;
    localparam logic [2:0] EV_FAILED  = 3'd4;
    localparam logic [2:0] EV_IGNORED = 3'd5;
    localparam logic [2:0] EV_FULL    = 3'd6;

    localparam logic [2:0] REG_OWN_ID    = 3'd0;
    localparam logic [2:0] REG_OWN_PORT  = 3'd1;
    localparam logic [2:0] REG_INTRO     = 3'd2;
    localparam logic [2:0] REG_FAIL_TCK  = 3'd3;
    localparam logic [2:0] REG_REMOVE_TCK = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic                load;     // capture input item
        logic                tick_pre; // advance time / own beat
        logic                visit;    // process slot at index
        logic [SLOT_W-1:0]   idx;
        logic                finish;   // apply gossip outcome
        logic                emit_tick;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_tick;
        logic sweep_on;    // tick sweep enabled (joined, >=2 members)
        logic gossip_done; // search resolved early
        logic removed;     // slot just visited was removed
    } t_sts;
endpackage
`default_nettype wire

@@ hw/rtl/hbmt_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbmt_ctrl
// Sequencer: walks table slots for each item and hands off results.
// ----------------------------------------------------------------------------
`default_nettype none
module hbmt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_out_free,
    input  wire hbmt_pkg::t_sts i_sts,
    output hbmt_pkg::t_cmd     o_cmd,
    output logic               o_push,
    output logic               o_push_last
);
    typedef enum logic [2:0] {S_IDLE, S_PRE, S_SCAN, S_WAIT, S_DONE} t_state;
    t_state r_state, n_state;
    logic [hbmt_pkg::SLOT_W-1:0] r_idx, n_idx;
    localparam logic [hbmt_pkg::SLOT_W-1:0] LAST_IDX = hbmt_pkg::SLOT_W'(hbmt_pkg::TABLE_DEPTH-1);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        o_cmd = '0;
        o_cmd.idx = r_idx;
        o_push = 1'b0;
        o_push_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                o_cmd.tick_pre = i_sts.is_tick;
                n_idx = hbmt_pkg::SLOT_W'(1);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // one slot per cycle while the output is free; a removal result must find the output free
                if (i_sts.is_tick && !i_sts.sweep_on) begin
                    n_state = S_DONE;
                end else if (!i_sts.is_tick && i_sts.gossip_done) begin
                    n_state = S_DONE;
                end else if (i_out_free) begin
                    o_cmd.visit = 1'b1;
                    if (r_idx == LAST_IDX) n_state = S_WAIT;
                    else n_idx = r_idx + 1'b1;
                end
            end
            S_WAIT: begin
                // removal result of the final slot comes back in status
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    if (i_sts.is_tick) o_cmd.emit_tick = 1'b1;
                    else o_cmd.finish = 1'b1;
                    o_push = 1'b1;
                    o_push_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_SCAN && o_cmd.visit && i_sts.is_tick) o_push = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
        end
    end

    property p_scan_start;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == S_PRE) |=> (r_idx == 1);
    endproperty
    a_scan_start: assert property (p_scan_start) else $error("scan index not 1");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(i_in_valid)) else $error("ready fell without item");
    a_done_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push_last) |-> (r_state == S_DONE)) else $error("last outside done");
endmodule
`default_nettype wire

@@ hw/rtl/hbmt_dp.sv @@
// ----------------------------------------------------------------------------
// hbmt_dp
// Datapath: table storage, config registers, per-slot update, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module hbmt_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hbmt_pkg::t_cmd i_cmd,
    input  wire logic          i_push,
    input  wire logic          i_push_last,
    output hbmt_pkg::t_sts     o_sts,
    // input item
    input  wire logic          i_op,
    input  wire logic [31:0]   i_member_id,
    input  wire logic [15:0]   i_member_port,
    input  wire logic [31:0]   i_beat_count,
    input  wire logic          i_reported_failed,
    input  wire logic          i_from_join_reply,
    // config write
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_addr,
    input  wire logic [31:0]   i_cfg_data,
    output logic [31:0]        o_cfg_rdata,
    // result register
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output logic [2:0]         o_event_res,
    output logic [31:0]        o_out_id,
    output logic [15:0]        o_out_port,
    output logic [4:0]         o_member_count,
    output logic               o_last,
    output logic               o_out_free
);
    localparam int D = hbmt_pkg::TABLE_DEPTH;
    localparam int SW = hbmt_pkg::SLOT_W;
    localparam int CW = hbmt_pkg::CNT_W;

    // configuration
    logic [31:0] r_own_id;
    logic [15:0] r_own_port, r_fail_ticks, r_remove_ticks;
    logic        r_intro;
    // table
    logic [D-1:0]  r_valid, r_failed;
    logic [31:0]   r_id [D];
    logic [15:0]   r_port [D];
    logic [31:0]   r_beat [D];
    logic [31:0]   r_stamp [D];
    logic [31:0]   r_time;
    logic          r_joined;
    logic [CW-1:0] r_count;
    // item
    logic          r_op, r_rfail, r_jrep;
    logic [31:0]   r_mid, r_mbeat;
    logic [15:0]   r_mport;
    // search result
    logic          r_hit, r_has_free, r_sweep;
    logic [SW-1:0] r_hit_idx, r_free_idx;
    logic          r_rm;
    logic [31:0]   r_rm_id;
    logic [15:0]   r_rm_port;
    // output register
    logic          r_ov;
    logic [2:0]    r_ev;
    logic [31:0]   r_oid;
    logic [15:0]   r_oport;
    logic [4:0]    r_ocnt;
    logic          r_olast;

    logic [SW-1:0] v;
    logic [31:0]   age;
    logic          own_match, slot_match;
    logic [2:0]    g_ev;

    assign v = i_cmd.idx;
    assign age = r_time - r_stamp[v];
    assign slot_match = r_valid[v] && r_id[v] == r_mid && r_port[v] == r_mport;
    assign own_match = r_mid == r_own_id && r_mport == r_own_port;

    assign o_sts.is_tick = ~r_op;
    assign o_sts.sweep_on = r_sweep;
    assign o_sts.gossip_done = own_match || r_hit;
    assign o_sts.removed = r_rm;

    // gossip outcome
    always_comb begin
        if (own_match) g_ev = hbmt_pkg::EV_IGNORED;
        else if (r_hit) begin
            if (r_failed[r_hit_idx]) g_ev = hbmt_pkg::EV_IGNORED;
            else if (r_rfail) g_ev = hbmt_pkg::EV_FAILED;
            else if (r_beat[r_hit_idx] < r_mbeat) g_ev = hbmt_pkg::EV_UPDATED;
            else g_ev = hbmt_pkg::EV_IGNORED;
        end else if (r_rfail) g_ev = hbmt_pkg::EV_IGNORED;
        else if (!r_has_free) g_ev = hbmt_pkg::EV_FULL;
        else g_ev = hbmt_pkg::EV_ADDED;
    end

    always_comb begin
        case (i_cfg_addr)
            hbmt_pkg::REG_OWN_ID:     o_cfg_rdata = r_own_id;
            hbmt_pkg::REG_OWN_PORT:   o_cfg_rdata = {16'd0, r_own_port};
            hbmt_pkg::REG_INTRO:      o_cfg_rdata = {31'd0, r_intro};
            hbmt_pkg::REG_FAIL_TCK:   o_cfg_rdata = {16'd0, r_fail_ticks};
            hbmt_pkg::REG_REMOVE_TCK: o_cfg_rdata = {16'd0, r_remove_ticks};
            default:                  o_cfg_rdata = '0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= '0; r_own_port <= '0; r_intro <= 1'b0;
            r_fail_ticks <= 16'd5; r_remove_ticks <= 16'd20;
            r_valid <= D'(1); r_failed <= '0;
            r_time <= '0; r_joined <= 1'b0; r_count <= CW'(1);
            r_ov <= 1'b0; r_rm <= 1'b0; r_op <= 1'b0;
            r_hit <= 1'b0; r_has_free <= 1'b0; r_sweep <= 1'b0;
        end else begin
            // removal of the slot visited this cycle
            r_rm <= i_cmd.visit && (v != '0) && !r_op && r_valid[v] && r_failed[v]
                    && (age > {16'd0, r_remove_ticks});
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    hbmt_pkg::REG_OWN_ID:     r_own_id <= i_cfg_data;
                    hbmt_pkg::REG_OWN_PORT:   r_own_port <= i_cfg_data[15:0];
                    hbmt_pkg::REG_INTRO: begin
                        r_intro <= i_cfg_data[0];
                        if (i_cfg_data[0]) r_joined <= 1'b1;
                    end
                    hbmt_pkg::REG_FAIL_TCK:   r_fail_ticks <= i_cfg_data[15:0];
                    hbmt_pkg::REG_REMOVE_TCK: r_remove_ticks <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_op <= i_op;
                r_hit <= 1'b0;
                r_has_free <= 1'b0;
            end
            if (i_cmd.tick_pre) begin
                r_time <= r_time + 32'd1;
                r_sweep <= r_joined && (r_count >= CW'(2));
            end
            if (i_cmd.visit && v != '0) begin
                if (r_op) begin
                    if (!r_valid[v] && !r_has_free) begin
                        r_has_free <= 1'b1;
                    end
                    if (slot_match && !r_hit) r_hit <= 1'b1;
                end else if (r_valid[v]) begin
                    if (!r_failed[v] && age > {16'd0, r_fail_ticks}) begin
                        r_failed[v] <= 1'b1;
                    end else if (r_failed[v] && age > {16'd0, r_remove_ticks}) begin
                        r_valid[v] <= 1'b0;
                        r_count <= r_count - 1'b1;
                    end
                end
            end
            if (i_cmd.finish) begin
                if (r_jrep) r_joined <= 1'b1;
                if (g_ev == hbmt_pkg::EV_FAILED) r_failed[r_hit_idx] <= 1'b1;
                if (g_ev == hbmt_pkg::EV_ADDED) begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_failed[r_free_idx] <= 1'b0;
                    r_count <= r_count + 1'b1;
                end
            end
            // result register: a new result replaces the one draining now
            if (i_push || r_rm) r_ov <= 1'b1;
            else if (r_ov && i_res_ready) r_ov <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cfg_we && i_cfg_addr == hbmt_pkg::REG_OWN_ID) r_id[0] <= i_cfg_data;
        if (i_cfg_we && i_cfg_addr == hbmt_pkg::REG_OWN_PORT) r_port[0] <= i_cfg_data[15:0];
        if (i_cmd.load) begin
            r_rfail <= i_reported_failed; r_jrep <= i_from_join_reply;
            r_mid <= i_member_id; r_mport <= i_member_port; r_mbeat <= i_beat_count;
        end
        if (i_cmd.tick_pre && r_joined) begin
            r_beat[0] <= r_beat[0] + 32'd1;
            r_stamp[0] <= r_time + 32'd1;
        end
        if (i_cmd.visit && v != '0) begin
            if (r_op) begin
                if (!r_valid[v] && !r_has_free) r_free_idx <= v;
                if (slot_match && !r_hit) r_hit_idx <= v;
            end else if (r_valid[v] && !r_failed[v] && age > {16'd0, r_fail_ticks}) begin
                r_stamp[v] <= r_time;
            end
            r_rm_id <= r_id[v];
            r_rm_port <= r_port[v];
        end
        if (i_cmd.finish) begin
            if (g_ev == hbmt_pkg::EV_FAILED || g_ev == hbmt_pkg::EV_UPDATED)
                r_stamp[r_hit_idx] <= r_time;
            if (g_ev == hbmt_pkg::EV_UPDATED) r_beat[r_hit_idx] <= r_mbeat;
            if (g_ev == hbmt_pkg::EV_ADDED) begin
                r_id[r_free_idx] <= r_mid; r_port[r_free_idx] <= r_mport;
                r_beat[r_free_idx] <= r_mbeat; r_stamp[r_free_idx] <= r_time;
            end
        end
        if (r_rm) begin
            r_ev <= hbmt_pkg::EV_REMOVED; r_oid <= r_rm_id; r_oport <= r_rm_port;
            r_ocnt <= 5'(r_count); r_olast <= 1'b0;
        end else if (i_cmd.emit_tick) begin
            r_ev <= hbmt_pkg::EV_TICK; r_oid <= '0; r_oport <= '0;
            r_ocnt <= 5'(r_count); r_olast <= i_push_last;
        end else if (i_cmd.finish) begin
            r_ev <= g_ev; r_oid <= r_mid; r_oport <= r_mport;
            r_ocnt <= 5'(r_count + ((g_ev == hbmt_pkg::EV_ADDED) ? CW'(1) : CW'(0)));
            r_olast <= i_push_last;
        end
    end

    // beat/stamp arrays have no reset value; r_bs_init keeps the output busy
    // while it is set from reset (added slots overwrite both beat and stamp)
    logic r_bs_init;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bs_init <= 1'b1;
        else r_bs_init <= 1'b0;
    end

    assign o_res_valid = r_ov;
    assign o_event_res = r_ev;
    assign o_out_id = r_oid;
    assign o_out_port = r_oport;
    assign o_member_count = r_ocnt;
    assign o_last = r_olast;
    // free when empty or draining; no push pending from a removal; not held by r_bs_init
    assign o_out_free = (!r_ov || i_res_ready) && !r_rm && !r_bs_init;

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid))) else $error("count mismatch");
    a_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[0] && !r_failed[0]) else $error("own slot lost");
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_res_ready) |=> r_ov) else $error("result dropped");
endmodule
`default_nettype wire

@@ hw/rtl/heartbeat_membership_table.sv @@
// ----------------------------------------------------------------------------
// heartbeat_membership_table
// Gossip heartbeat failure detector: membership table with tick sweep.
//
// Channel   Dir  Contents
// s_axis    in   tdata: op, member_id, member_port, beat_count, reported_failed,
//                from_join_reply
// m_axis    out  tdata: event_res, out_id, out_port, member_count; tlast: last
// apb       cfg  own_id, own_port, is_introducer, fail_ticks, remove_ticks
//
// The slot walk paces the items: a new item is accepted only from idle, and a
// full walk runs setup, a visit to each of the 15 slots, wait and result, then idle.
// A tick with the sweep off, or gossip for the own entry, skips the visits; gossip
// that matches slot k stops the walk after that slot.
// Reset is synchronous; slot zero is valid, time and joined are cleared.
// Each removal holds the walk, and a stalled result register holds it too.
// ----------------------------------------------------------------------------
`default_nettype none
module heartbeat_membership_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] op, [32:1] member_id, [48:33] member_port, [80:49] beat_count,
    // [81] reported_failed, [82] from_join_reply
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] event_res, [34:3] out_id, [50:35] out_port, [55:51] member_count
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    hbmt_pkg::t_cmd cmd;
    hbmt_pkg::t_sts sts;
    logic push, push_last, out_free, cfg_we;
    logic [2:0] ev;
    logic [31:0] oid;
    logic [15:0] oport;
    logic [4:0] ocnt;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    hbmt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_out_free(out_free), .i_sts(sts), .o_cmd(cmd),
        .o_push(push), .o_push_last(push_last)
    );

    hbmt_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_push(push), .i_push_last(push_last), .o_sts(sts),
        .i_op(s_axis_tdata[0]), .i_member_id(s_axis_tdata[32:1]),
        .i_member_port(s_axis_tdata[48:33]), .i_beat_count(s_axis_tdata[80:49]),
        .i_reported_failed(s_axis_tdata[81]), .i_from_join_reply(s_axis_tdata[82]),
        .i_cfg_we(cfg_we), .i_cfg_addr(paddr[4:2]), .i_cfg_data(pwdata),
        .o_cfg_rdata(prdata),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .o_event_res(ev), .o_out_id(oid), .o_out_port(oport),
        .o_member_count(ocnt), .o_last(m_axis_tlast), .o_out_free(out_free)
    );

    assign m_axis_tdata = {ocnt, oport, oid, ev};
endmodule
`default_nettype wire
